>>> rtl/core/pqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqs_pkg
// shared types, register indexes, midi codes and the pitch table
// ----------------------------------------------------------------------------
package pqs_pkg;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ATTACK_LENGTH  = 3'd0,
    REG_ATTACK_STEP    = 3'd1,
    REG_DECAY_LENGTH   = 3'd2,
    REG_DECAY_STEP     = 3'd3,
    REG_HOLD_LEVEL     = 3'd4,
    REG_RELEASE_LENGTH = 3'd5,
    REG_RELEASE_FACTOR = 3'd6,
    REG_LEVEL_FLOOR    = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_ATTACK  = 3'd0,
    ST_DECAY   = 3'd1,
    ST_SUSTAIN = 3'd2,
    ST_RELEASE = 3'd3,
    ST_OFF     = 3'd4
  } env_stage_t;

  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [7:0] STATUS_STOP  = 8'hFC;
  localparam logic [7:0] STATUS_RESET = 8'hFF;

  localparam int CFG_DATA_BITS = 17;

  typedef struct packed {
    logic [15:0] attack_length;
    logic [16:0] attack_step;
    logic [15:0] decay_length;
    logic [16:0] decay_step;
    logic [16:0] hold_level;
    logic [15:0] release_length;
    logic [15:0] release_factor;
    logic [16:0] level_floor;
  } cfg_t;

  // increments of notes 120..131 at 24 bits
  function automatic logic [24:0] top_inc(input logic [3:0] s);
    logic [24:0] r;
    unique case (s)
      4'd0:    r = 25'd12740059;
      4'd1:    r = 25'd13497623;
      4'd2:    r = 25'd14300233;
      4'd3:    r = 25'd15150569;
      4'd4:    r = 25'd16051469;
      4'd5:    r = 25'd17005939;
      4'd6:    r = 25'd18017165;
      4'd7:    r = 25'd19088521;
      4'd8:    r = 25'd20223584;
      4'd9:    r = 25'd21426141;
      4'd10:   r = 25'd22700205;
      4'd11:   r = 25'd24050030;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

  // increment at 24 bits for a note, from the top octave by rounded shift
  function automatic logic [24:0] note_inc(input logic [6:0] n);
    logic [14:0] q;
    logic [3:0]  oct;
    logic [3:0]  semi;
    logic [3:0]  sh;
    logic [25:0] v;
    // octave as (n * 171) >> 11, exact for seven-bit notes
    q    = 15'(n) * 15'd171;
    oct  = 4'(q >> 11);
    semi = 4'(n - 7'(oct) * 7'd12);
    sh   = 4'd10 - oct;
    v    = {1'b0, top_inc(semi)};
    if (sh != 4'd0) begin
      v = (v + (26'd1 << (sh - 4'd1))) >> sh;
    end
    return v[24:0];
  endfunction

endpackage

>>> rtl/core/pqs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqs_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module pqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/pqs_voice_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqs_voice_update
// two-stage envelope and phase step for one voice record per cycle
// ----------------------------------------------------------------------------
module pqs_voice_update #(
  parameter int PHASE_BITS      = 24,
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int TICK_BITS       = 16
) (
  input  logic                       clk,
  input  pqs_pkg::cfg_t              cfg,
  input  logic [2:0]                 stage_in,
  input  logic [TICK_BITS-1:0]       ticks_in,
  input  logic [LEVEL_FRAC_BITS:0]   level_in,
  input  logic [PHASE_BITS-1:0]      phase_in,
  input  logic [6:0]                 note_in,
  output logic [2:0]                 stage_out,
  output logic [TICK_BITS-1:0]       ticks_out,
  output logic [LEVEL_FRAC_BITS:0]   level_out,
  output logic [PHASE_BITS-1:0]      phase_out
);

  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam int PW = TICK_BITS + 17;
  localparam logic [PW-1:0] ONE_P = PW'(1) << LEVEL_FRAC_BITS;
  localparam logic [LW-1:0] ONE_L = LW'(1) << LEVEL_FRAC_BITS;

  // stage one: multiply
  logic [2:0]           s1_stage;
  logic [TICK_BITS-1:0] s1_ticks;
  logic [PW-1:0]        s1_prod;
  logic [LW+15:0]       s1_rel;
  logic [PHASE_BITS-1:0] s1_phase;
  logic [24:0]          s1_inc;

  always_ff @(posedge clk) begin
    s1_stage <= stage_in;
    s1_ticks <= ticks_in;
    s1_prod  <= (stage_in == pqs_pkg::ST_ATTACK)
                ? PW'(ticks_in) * PW'(cfg.attack_step)
                : PW'(ticks_in) * PW'(cfg.decay_step);
    s1_rel   <= (LW + 16)'(level_in) * (LW + 16)'(cfg.release_factor);
    s1_phase <= phase_in;
    s1_inc   <= pqs_pkg::note_inc(note_in);
  end

  logic [TICK_BITS-1:0]  tick_inc;
  logic [LW-1:0]         rel_lvl;
  logic [LW-1:0]         sus_lvl;
  logic [PHASE_BITS-1:0] inc_p;

  assign tick_inc = s1_ticks + TICK_BITS'(1);
  assign rel_lvl  = LW'(s1_rel >> 16);
  assign sus_lvl  = (32'(cfg.hold_level) > 32'(ONE_L)) ? ONE_L : LW'(cfg.hold_level);

  always_comb begin
    if (PHASE_BITS >= 24) begin
      inc_p = PHASE_BITS'({7'd0, s1_inc} << (PHASE_BITS - 24));
    end else begin
      inc_p = PHASE_BITS'(s1_inc >> (24 - PHASE_BITS));
    end
  end

  always_comb begin
    stage_out = s1_stage;
    ticks_out = s1_ticks;
    level_out = '0;
    unique case (s1_stage)
      pqs_pkg::ST_ATTACK: begin
        level_out = (s1_prod > ONE_P) ? ONE_L : LW'(s1_prod);
        ticks_out = tick_inc;
        if (32'(tick_inc) >= 32'(cfg.attack_length)) begin
          stage_out = pqs_pkg::ST_DECAY;
          ticks_out = '0;
        end
      end
      pqs_pkg::ST_DECAY: begin
        level_out = (s1_prod > ONE_P) ? '0 : LW'(ONE_P - s1_prod);
        ticks_out = tick_inc;
        if (32'(tick_inc) >= 32'(cfg.decay_length)) begin
          stage_out = pqs_pkg::ST_SUSTAIN;
        end
      end
      pqs_pkg::ST_SUSTAIN: level_out = sus_lvl;
      pqs_pkg::ST_RELEASE: begin
        level_out = rel_lvl;
        ticks_out = tick_inc;
        if (32'(tick_inc) >= 32'(cfg.release_length) ||
            32'(rel_lvl) <= 32'(cfg.level_floor)) begin
          stage_out = pqs_pkg::ST_OFF;
          level_out = '0;
        end
      end
      default: level_out = '0;
    endcase
  end

  assign phase_out = s1_phase + inc_p;

endmodule

>>> rtl/core/polyphonic_square_adsr_synth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_square_adsr_synth
// multi-voice square synthesiser with adsr envelopes and a one-bit output
// ----------------------------------------------------------------------------
// Voice records live in one synchronous ram, one word per voice. A sample
// tick walks the voices through read, multiply and write stages and then
// loads the result register, after which the input is ready again; the walk
// holds at its end while an earlier result is still waiting. A midi request
// walks the voices and the input is ready again when that walk ends. The
// single ram read port makes both walks visit the voices one after another.
// After reset a clearing pass writes every record before the first request
// is taken.
// One result request per sample tick, none per midi request.
module polyphonic_square_adsr_synth #(
  parameter int VOICE_COUNT     = 8,
  parameter int PHASE_BITS      = 24,
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int TICK_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // status_byte, note_number, velocity
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // audio_bit, any_sounding, mix_sum
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int VB = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam int RW = 1 + 7 + PHASE_BITS + 3 + TICK_BITS + LW;
  localparam int CW = VB + 1;

  typedef struct packed {
    logic                  active;
    logic [6:0]            note;
    logic [PHASE_BITS-1:0] phase;
    logic [2:0]            stage;
    logic [TICK_BITS-1:0]  ticks;
    logic [LW-1:0]         level;
  } voice_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MIDI  = 5'b00100,
    S_TICK  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  pqs_pkg::cfg_t cfg;

  // configuration
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_length  <= 16'd300;
      cfg.attack_step    <= 17'd218;
      cfg.decay_length   <= 16'd200;
      cfg.decay_step     <= 17'd131;
      cfg.hold_level     <= 17'd39322;
      cfg.release_length <= 16'd500;
      cfg.release_factor <= 16'd65405;
      cfg.level_floor    <= 17'd66;
    end else if (cfg_valid) begin
      unique case (pqs_pkg::cfg_reg_t'(cfg_index))
        pqs_pkg::REG_ATTACK_LENGTH:  cfg.attack_length  <= cfg_data[15:0];
        pqs_pkg::REG_ATTACK_STEP:    cfg.attack_step    <= cfg_data;
        pqs_pkg::REG_DECAY_LENGTH:   cfg.decay_length   <= cfg_data[15:0];
        pqs_pkg::REG_DECAY_STEP:     cfg.decay_step     <= cfg_data;
        pqs_pkg::REG_HOLD_LEVEL:     cfg.hold_level     <= cfg_data;
        pqs_pkg::REG_RELEASE_LENGTH: cfg.release_length <= cfg_data[15:0];
        pqs_pkg::REG_RELEASE_FACTOR: cfg.release_factor <= cfg_data[15:0];
        pqs_pkg::REG_LEVEL_FLOOR:    cfg.level_floor    <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  logic [7:0] req_status;
  logic [6:0] req_note;
  logic [6:0] req_vel;
  logic       claimed;

  assign s_tready = (state == S_IDLE);
  wire in_acc = s_tvalid && s_tready;

  // sequencer
  logic [CW-1:0] rd_cnt;
  logic [VB-1:0] ram_raddr;
  logic          ram_we;
  logic [VB-1:0] ram_waddr;
  voice_t        ram_wdata;
  voice_t        ram_rdata;
  logic [RW-1:0] ram_rraw;

  pqs_ram #(.WIDTH(RW), .DEPTH(VOICE_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (RW'(ram_wdata)),
    .raddr (ram_raddr),
    .rdata (ram_rraw)
  );
  assign ram_rdata = voice_t'(ram_rraw);
  assign ram_raddr = rd_cnt[VB-1:0];

  // read valid pipe: d1 = data on ram port, d2 = after multiply stage
  logic          d1_v, d2_v;
  logic [VB-1:0] d1_a, d2_a;
  voice_t        d2_rec;
  logic          d2_snd;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= 1'b0;
      d2_v <= 1'b0;
    end else begin
      d1_v <= (state == S_MIDI || state == S_TICK) && (rd_cnt < CW'(VOICE_COUNT));
      d2_v <= d1_v && (state == S_TICK);
    end
  end
  always_ff @(posedge clk) begin
    d1_a   <= rd_cnt[VB-1:0];
    d2_a   <= d1_a;
    d2_rec <= ram_rdata;
    d2_snd <= ram_rdata.active && (ram_rdata.stage < pqs_pkg::ST_OFF);
  end

  // tick datapath
  logic [2:0]            up_stage;
  logic [TICK_BITS-1:0]  up_ticks;
  logic [LW-1:0]         up_level;
  logic [PHASE_BITS-1:0] up_phase;

  pqs_voice_update #(
    .PHASE_BITS(PHASE_BITS), .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS), .TICK_BITS(TICK_BITS)
  ) u_update (
    .clk       (clk),
    .cfg       (cfg),
    .stage_in  (ram_rdata.stage),
    .ticks_in  (ram_rdata.ticks),
    .level_in  (ram_rdata.level),
    .phase_in  (ram_rdata.phase),
    .note_in   (ram_rdata.note),
    .stage_out (up_stage),
    .ticks_out (up_ticks),
    .level_out (up_level),
    .phase_out (up_phase)
  );

  localparam int MW = (LW + VB + 2 > 22) ? LW + VB + 2 : 22;
  logic signed [MW-1:0] mix;
  logic                 any;

  wire [3:0] cmd   = req_status[7:4];
  wire is_on       = (cmd == pqs_pkg::CMD_NOTE_ON) && (req_vel != 7'd0);
  wire is_off      = (cmd == pqs_pkg::CMD_NOTE_OFF) || (cmd == pqs_pkg::CMD_NOTE_ON);
  wire is_stop     = (req_status == pqs_pkg::STATUS_STOP) ||
                     (req_status == pqs_pkg::STATUS_RESET);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = d1_a;
    ram_wdata = ram_rdata;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = rd_cnt[VB-1:0];
      ram_wdata = '0;
    end else if (state == S_MIDI && d1_v) begin
      if (is_on) begin
        if (!claimed && (!ram_rdata.active || ram_rdata.stage == pqs_pkg::ST_OFF)) begin
          ram_we    = 1'b1;
          ram_wdata = '0;
          ram_wdata.active = 1'b1;
          ram_wdata.note   = req_note;
          ram_wdata.stage  = pqs_pkg::ST_ATTACK;
        end
      end else if (is_off) begin
        if (ram_rdata.active && ram_rdata.note == req_note) begin
          ram_we = 1'b1;
          ram_wdata.stage = pqs_pkg::ST_RELEASE;
          ram_wdata.ticks = '0;
        end
      end else if (is_stop) begin
        ram_we = 1'b1;
        ram_wdata.stage = pqs_pkg::ST_RELEASE;
        ram_wdata.ticks = '0;
      end
    end else if (d2_v) begin
      ram_we    = 1'b1;
      ram_waddr = d2_a;
      ram_wdata = d2_rec;
      if (d2_snd) begin
        ram_wdata.stage = up_stage;
        ram_wdata.ticks = up_ticks;
        ram_wdata.level = up_level;
        ram_wdata.phase = up_phase;
      end else begin
        ram_wdata.active = 1'b0;
      end
    end
  end

  // output register
  localparam logic signed [MW-1:0] LIM_HI = MW'((1 << 20) - 1);
  localparam logic signed [MW-1:0] LIM_LO = -MW'(1 << 20);
  logic        out_bit;
  logic        out_any;
  logic [20:0] out_mix;
  logic signed [MW-1:0] shown;

  always_comb begin
    if (mix > LIM_HI) shown = LIM_HI;
    else if (mix < LIM_LO) shown = LIM_LO;
    else shown = mix;
  end
  assign m_tdata = {1'b0, out_mix, out_any, out_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      rd_cnt   <= '0;
      m_tvalid <= 1'b0;
      claimed  <= 1'b0;
      mix      <= '0;
      any      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == S_MIDI && d1_v && is_on && ram_we) claimed <= 1'b1;
      if (d2_v && d2_snd) begin
        any <= 1'b1;
        if (!up_phase[PHASE_BITS-1]) mix <= mix + MW'(up_level);
        else mix <= mix - MW'(up_level);
      end
      unique case (state)
        S_CLEAR: begin
          if (rd_cnt == CW'(VOICE_COUNT - 1)) begin
            rd_cnt <= '0;
            state  <= S_IDLE;
          end else begin
            rd_cnt <= rd_cnt + CW'(1);
          end
        end
        S_IDLE: begin
          rd_cnt  <= '0;
          claimed <= 1'b0;
          mix     <= '0;
          any     <= 1'b0;
          if (in_acc) state <= s_tuser ? S_MIDI : S_TICK;
        end
        S_MIDI: begin
          if (rd_cnt < CW'(VOICE_COUNT)) rd_cnt <= rd_cnt + CW'(1);
          else if (!d1_v) state <= S_IDLE;
        end
        S_TICK: begin
          if (rd_cnt < CW'(VOICE_COUNT)) rd_cnt <= rd_cnt + CW'(1);
          else if (!d1_v && !d2_v && (!m_tvalid || m_tready)) state <= S_OUT;
        end
        S_OUT: begin
          m_tvalid <= 1'b1;
          out_bit  <= (mix >= 0);
          out_any  <= any;
          out_mix  <= 21'(shown);
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_status <= s_tdata[7:0];
      req_note   <= s_tdata[14:8];
      req_vel    <= s_tdata[21:15];
    end
  end

  // checks
  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("accept while busy");
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT)) else $error("result without tick");
  a_stage_pipe: assert property (@(posedge clk) disable iff (rst)
    d2_v |-> $past(d1_v)) else $error("write-back without read");

endmodule
